// ===== hdl/dmslc_pkg.sv =====
// ----------------------------------------------------------------------------
// dmslc_pkg: shared types and constants
// Field widths, request codes, register indexes and reset values for the
// dual motor step/limit controller.
// ----------------------------------------------------------------------------
package dmslc_pkg;

  // Field widths
  localparam int PWM_BITS      = 12;
  localparam int COUNT_BITS    = 18;
  localparam int SPEED_BITS    = PWM_BITS + 1;
  localparam int STEP_BITS     = 16;
  localparam int FREE_BITS     = COUNT_BITS - 1;
  localparam int REQ_BITS      = 3;
  localparam int CFG_ADDR_BITS = 4;
  localparam int CFG_DATA_BITS = 32;
  localparam int CFG_IDX_BITS  = 2;

  typedef logic [PWM_BITS-1:0]          duty_t;
  typedef logic signed [COUNT_BITS-1:0] count_t;
  typedef logic signed [SPEED_BITS-1:0] speed_t;
  typedef logic signed [STEP_BITS-1:0]  steps_t;
  typedef logic [FREE_BITS-1:0]         free_t;
  typedef logic [REQ_BITS-1:0]          req_t;
  typedef logic [CFG_IDX_BITS-1:0]      cfg_idx_t;

  // Request codes
  localparam req_t REQ_DRIVE      = 3'd0;
  localparam req_t REQ_STEP       = 3'd1;
  localparam req_t REQ_SERVO      = 3'd2;
  localparam req_t REQ_LEFT_TICK  = 3'd3;
  localparam req_t REQ_RIGHT_TICK = 3'd4;
  localparam req_t REQ_POLL       = 3'd5;

  // Configuration register indexes (byte address = 4 * index)
  localparam cfg_idx_t CFG_SERVO_FLOOR = 2'd0;
  localparam cfg_idx_t CFG_SERVO_CEIL  = 2'd1;
  localparam cfg_idx_t CFG_FREE_RUN    = 2'd2;

  // Register reset values
  localparam duty_t SERVO_FLOOR_RST = 12'd150;
  localparam duty_t SERVO_CEIL_RST  = 12'd600;
  localparam free_t FREE_RUN_RST    = 17'd9999;

  // Direction encoding
  localparam logic DIR_FWD = 1'b0;
  localparam logic DIR_REV = 1'b1;

  // Count saturation bounds
  localparam count_t COUNT_MAX = {1'b0, {(COUNT_BITS-1){1'b1}}};
  localparam count_t COUNT_MIN = {1'b1, {(COUNT_BITS-1){1'b0}}};

endpackage

// ===== hdl/dmslc_if.sv =====
// ----------------------------------------------------------------------------
// dmslc_if: request and result channel interfaces
// Valid/ready channels; a transaction moves at a clock edge with valid and
// ready both high.
// ----------------------------------------------------------------------------
interface dmslc_in_if;
  import dmslc_pkg::*;

  logic   valid;
  logic   ready;
  req_t   req_type;
  speed_t left_speed;
  speed_t right_speed;
  steps_t left_steps;
  steps_t right_steps;
  duty_t  servo_pos;

  modport source (
    output valid, req_type, left_speed, right_speed, left_steps, right_steps,
           servo_pos,
    input  ready
  );
  modport sink (
    input  valid, req_type, left_speed, right_speed, left_steps, right_steps,
           servo_pos,
    output ready
  );
endinterface

interface dmslc_out_if;
  import dmslc_pkg::*;

  logic   valid;
  logic   ready;
  duty_t  left_fwd_duty;
  duty_t  left_rev_duty;
  duty_t  right_fwd_duty;
  duty_t  right_rev_duty;
  duty_t  servo_duty;
  count_t left_count;
  count_t right_count;
  logic   left_limit_hit;
  logic   right_limit_hit;

  modport source (
    output valid, left_fwd_duty, left_rev_duty, right_fwd_duty, right_rev_duty,
           servo_duty, left_count, right_count, left_limit_hit, right_limit_hit,
    input  ready
  );
  modport sink (
    input  valid, left_fwd_duty, left_rev_duty, right_fwd_duty, right_rev_duty,
           servo_duty, left_count, right_count, left_limit_hit, right_limit_hit,
    output ready
  );
endinterface

// ===== hdl/dual_motor_step_limit_controller.sv =====
// Each request (drive, step, servo, left/right encoder tick, poll) is captured
// in an input register; on the next cycle in which the result stage is free it
// updates the controller state in one combinational pass, and the result
// (duties, slit counts and limit-hit flags after the update) is presented from
// the state and hit registers. Throughput is one request per clock while the
// result channel is not stalled; a request passes the input register and then
// the state registers on its way to a valid result. The input register
// takes one more request while a finished result waits. Registers sit on an
// APB port at byte addresses 0 (servo floor), 4 (servo ceiling) and 8
// (free_run_limit); write them only while no request is in flight.
// ----------------------------------------------------------------------------
// dual_motor_step_limit_controller: two-motor drive with encoder step limits
// Drive/step commands produce forward/reverse PWM duty pairs, encoder ticks
// update signed slit counts, polls stop sides that reached their limit, and
// servo requests clamp the servo duty into a configured window.
// ----------------------------------------------------------------------------
module dual_motor_step_limit_controller (
  input  logic                                  clk,
  input  logic                                  rst_n,
  dmslc_in_if.sink                              in_if,
  dmslc_out_if.source                           out_if,
  input  logic                                  psel,
  input  logic                                  penable,
  input  logic                                  pwrite,
  input  logic [dmslc_pkg::CFG_ADDR_BITS-1:0]   paddr,
  input  logic [dmslc_pkg::CFG_DATA_BITS-1:0]   pwdata,
  output logic [dmslc_pkg::CFG_DATA_BITS-1:0]   prdata,
  output logic                                  pready
);
  import dmslc_pkg::*;

  typedef struct packed {
    duty_t fwd;
    duty_t rev;
    logic  dir;
    logic  stop;
  } drive_t;

  // Speed to duty pair; magnitude saturates at full duty
  function automatic drive_t drive_side(speed_t v);
    logic [SPEED_BITS-1:0] mag;
    duty_t                 duty;
    drive_t                d;
    mag    = v[SPEED_BITS-1] ? (~v + 1'b1) : v;
    duty   = mag[SPEED_BITS-1] ? {PWM_BITS{1'b1}} : mag[PWM_BITS-1:0];
    d.dir  = v[SPEED_BITS-1] ? DIR_REV : DIR_FWD;
    d.fwd  = v[SPEED_BITS-1] ? '0 : duty;
    d.rev  = v[SPEED_BITS-1] ? duty : '0;
    d.stop = (v == '0);
    return d;
  endfunction

  // count +/- steps, saturated to the count range
  function automatic count_t step_limit(count_t c, logic dir, steps_t s);
    logic signed [COUNT_BITS:0] ce;
    logic signed [COUNT_BITS:0] se;
    logic signed [COUNT_BITS:0] sum;
    ce  = {c[COUNT_BITS-1], c};
    se  = {{(COUNT_BITS+1-STEP_BITS){s[STEP_BITS-1]}}, s};
    sum = (dir == DIR_REV) ? (ce - se) : (ce + se);
    if (sum[COUNT_BITS] != sum[COUNT_BITS-1]) begin
      return sum[COUNT_BITS] ? COUNT_MIN : COUNT_MAX;
    end
    return sum[COUNT_BITS-1:0];
  endfunction

  // One encoder slit in the current direction, saturated
  function automatic count_t tick(count_t c, logic dir);
    if (dir == DIR_REV) begin
      return (c == COUNT_MIN) ? c : count_t'(c - 1'b1);
    end
    return (c == COUNT_MAX) ? c : count_t'(c + 1'b1);
  endfunction

  // Magnitude of a count; fits unsigned in the same width
  function automatic logic [COUNT_BITS-1:0] count_mag(count_t c);
    return c[COUNT_BITS-1] ? (~c + 1'b1) : c;
  endfunction

  // Configuration registers
  duty_t    servo_floor_r;
  duty_t    servo_ceil_r;
  free_t    free_run_r;
  cfg_idx_t cfg_idx;
  logic     cfg_wr;

  // Input register
  logic   in_valid_r;
  req_t   in_req_r;
  speed_t in_ls_r;
  speed_t in_rs_r;
  steps_t in_lst_r;
  steps_t in_rst_r;
  duty_t  in_pos_r;
  logic   adv;

  // Controller state; also serves as the result register
  logic   out_valid_r;
  duty_t  lfwd_r, lrev_r, rfwd_r, rrev_r, servo_r;
  duty_t  lfwd_nxt, lrev_nxt, rfwd_nxt, rrev_nxt, servo_nxt;
  count_t lcnt_r, rcnt_r, lcnt_nxt, rcnt_nxt;
  count_t llim_r, rlim_r, llim_nxt, rlim_nxt;
  logic   ldir_r, rdir_r, ldir_nxt, rdir_nxt;
  logic   lhit_r, rhit_r, lhit_nxt, rhit_nxt;

  // Intermediate terms of the update
  drive_t dl, dr;
  count_t lcnt_drv, rcnt_drv;
  duty_t  pos_lo, pos_cl;
  logic   lpoll_hit, rpoll_hit;

  // ---------------- configuration port ----------------
  assign pready  = 1'b1;
  assign cfg_idx = paddr[CFG_ADDR_BITS-1:2];
  assign cfg_wr  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      servo_floor_r <= SERVO_FLOOR_RST;
      servo_ceil_r  <= SERVO_CEIL_RST;
      free_run_r    <= FREE_RUN_RST;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        CFG_SERVO_FLOOR: servo_floor_r <= pwdata[PWM_BITS-1:0];
        CFG_SERVO_CEIL:  servo_ceil_r  <= pwdata[PWM_BITS-1:0];
        CFG_FREE_RUN:    free_run_r    <= pwdata[FREE_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      CFG_SERVO_FLOOR: prdata = CFG_DATA_BITS'(servo_floor_r);
      CFG_SERVO_CEIL:  prdata = CFG_DATA_BITS'(servo_ceil_r);
      CFG_FREE_RUN:    prdata = CFG_DATA_BITS'(free_run_r);
      default:         prdata = '0;
    endcase
  end

  // ---------------- handshake ----------------
  // Input register moves on when the result stage is empty or being drained
  assign adv         = in_valid_r && (!out_valid_r || out_if.ready);
  assign in_if.ready = !in_valid_r || adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_if.ready) begin
        in_valid_r <= in_if.valid;
      end
      if (adv) begin
        out_valid_r <= 1'b1;
      end else if (out_if.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_if.ready) begin
      in_req_r <= in_if.req_type;
      in_ls_r  <= in_if.left_speed;
      in_rs_r  <= in_if.right_speed;
      in_lst_r <= in_if.left_steps;
      in_rst_r <= in_if.right_steps;
      in_pos_r <= in_if.servo_pos;
    end
  end

  // ---------------- update terms ----------------
  assign dl       = drive_side(in_ls_r);
  assign dr       = drive_side(in_rs_r);
  assign lcnt_drv = dl.stop ? '0 : lcnt_r;
  assign rcnt_drv = dr.stop ? '0 : rcnt_r;

  assign pos_lo = (in_pos_r < servo_floor_r) ? servo_floor_r : in_pos_r;
  assign pos_cl = (pos_lo > servo_ceil_r) ? servo_ceil_r : pos_lo;

  assign lpoll_hit = (llim_r != '0) && (count_mag(lcnt_r) >= count_mag(llim_r));
  assign rpoll_hit = (rlim_r != '0) && (count_mag(rcnt_r) >= count_mag(rlim_r));

  // ---------------- next state ----------------
  always_comb begin
    lfwd_nxt  = lfwd_r;
    lrev_nxt  = lrev_r;
    rfwd_nxt  = rfwd_r;
    rrev_nxt  = rrev_r;
    servo_nxt = servo_r;
    lcnt_nxt  = lcnt_r;
    rcnt_nxt  = rcnt_r;
    llim_nxt  = llim_r;
    rlim_nxt  = rlim_r;
    ldir_nxt  = ldir_r;
    rdir_nxt  = rdir_r;
    lhit_nxt  = lhit_r;
    rhit_nxt  = rhit_r;
    if (adv) begin
      lhit_nxt = 1'b0;
      rhit_nxt = 1'b0;
      unique case (in_req_r) inside
        REQ_DRIVE, REQ_STEP: begin
          lfwd_nxt = dl.fwd;
          lrev_nxt = dl.rev;
          ldir_nxt = dl.dir;
          lcnt_nxt = lcnt_drv;
          rfwd_nxt = dr.fwd;
          rrev_nxt = dr.rev;
          rdir_nxt = dr.dir;
          rcnt_nxt = rcnt_drv;
          if (in_req_r == REQ_STEP) begin
            llim_nxt = step_limit(lcnt_drv, dl.dir, in_lst_r);
            rlim_nxt = step_limit(rcnt_drv, dr.dir, in_rst_r);
          end else begin
            llim_nxt = COUNT_BITS'(free_run_r);
            rlim_nxt = COUNT_BITS'(free_run_r);
          end
        end
        REQ_SERVO: begin
          servo_nxt = pos_cl;
        end
        REQ_LEFT_TICK: begin
          lcnt_nxt = tick(lcnt_r, ldir_r);
        end
        REQ_RIGHT_TICK: begin
          rcnt_nxt = tick(rcnt_r, rdir_r);
        end
        REQ_POLL: begin
          if (lpoll_hit) begin
            lfwd_nxt = '0;
            lrev_nxt = '0;
            ldir_nxt = DIR_FWD;
            lcnt_nxt = '0;
            llim_nxt = '0;
            lhit_nxt = 1'b1;
          end
          if (rpoll_hit) begin
            rfwd_nxt = '0;
            rrev_nxt = '0;
            rdir_nxt = DIR_FWD;
            rcnt_nxt = '0;
            rlim_nxt = '0;
            rhit_nxt = 1'b1;
          end
        end
        default: ;  // unused codes leave the state alone
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lfwd_r  <= '0;
      lrev_r  <= '0;
      rfwd_r  <= '0;
      rrev_r  <= '0;
      servo_r <= '0;
      lcnt_r  <= '0;
      rcnt_r  <= '0;
      llim_r  <= '0;
      rlim_r  <= '0;
      ldir_r  <= DIR_FWD;
      rdir_r  <= DIR_FWD;
      lhit_r  <= 1'b0;
      rhit_r  <= 1'b0;
    end else begin
      lfwd_r  <= lfwd_nxt;
      lrev_r  <= lrev_nxt;
      rfwd_r  <= rfwd_nxt;
      rrev_r  <= rrev_nxt;
      servo_r <= servo_nxt;
      lcnt_r  <= lcnt_nxt;
      rcnt_r  <= rcnt_nxt;
      llim_r  <= llim_nxt;
      rlim_r  <= rlim_nxt;
      ldir_r  <= ldir_nxt;
      rdir_r  <= rdir_nxt;
      lhit_r  <= lhit_nxt;
      rhit_r  <= rhit_nxt;
    end
  end

  // ---------------- result channel ----------------
  assign out_if.valid           = out_valid_r;
  assign out_if.left_fwd_duty   = lfwd_r;
  assign out_if.left_rev_duty   = lrev_r;
  assign out_if.right_fwd_duty  = rfwd_r;
  assign out_if.right_rev_duty  = rrev_r;
  assign out_if.servo_duty      = servo_r;
  assign out_if.left_count      = lcnt_r;
  assign out_if.right_count     = rcnt_r;
  assign out_if.left_limit_hit  = lhit_r;
  assign out_if.right_limit_hit = rhit_r;

  // ---------------- assertions ----------------
  // Hit flags only come from a poll transaction
  a_hit_only_poll: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && in_req_r != REQ_POLL) |=> (!lhit_r && !rhit_r))
    else $error("limit hit flagged on a non-poll transaction");

  // A left hit leaves the side fully stopped
  a_left_stop: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && lhit_nxt) |=> (lcnt_r == '0 && llim_r == '0 && ldir_r == DIR_FWD
                           && lfwd_r == '0 && lrev_r == '0))
    else $error("left side not stopped after limit hit");

  // A right hit leaves the side fully stopped
  a_right_stop: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && rhit_nxt) |=> (rcnt_r == '0 && rlim_r == '0 && rdir_r == DIR_FWD
                           && rfwd_r == '0 && rrev_r == '0))
    else $error("right side not stopped after limit hit");

  // Forward and reverse duties are never active together
  a_duty_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    (lfwd_r == '0 || lrev_r == '0) && (rfwd_r == '0 || rrev_r == '0))
    else $error("forward and reverse duty both nonzero");

  // A stalled result with a waiting request blocks new input
  a_stall_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_if.ready && in_valid_r) |-> !in_if.ready)
    else $error("input accepted while both stages are full and stalled");

  // The state does not change while a result is stalled
  a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_if.ready) |=> ($stable(lcnt_r) && $stable(rcnt_r)
                                        && $stable(servo_r)))
    else $error("state changed under a stalled result");

endmodule
